// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the lattice path counter; only the top level includes them.
// No dependencies; take in with a bare include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gpck_pkg.sv =====
// Package for the knight-blocked lattice path counter: sizes, types, helpers.
// No dependencies.
package gpck_pkg;

    localparam int MAX_DIM = 32;
    localparam int NUM_COLS = MAX_DIM + 1;
    localparam int IDX_W = $clog2(NUM_COLS);
    localparam int FIELD_W = 6;
    localparam int CNT_W = 61;
    localparam int DIFF_W = FIELD_W + 1;

    localparam logic [FIELD_W-1:0] DIM_MAX = FIELD_W'(MAX_DIM);

    typedef logic [CNT_W-1:0] count_t;

    // Position of the cell being updated and the knight square.
    typedef struct packed {
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [FIELD_W-1:0] knight_row;
        logic [FIELD_W-1:0] knight_col;
    } pos_t;

    // Absolute distance between a grid index and a knight coordinate.
    function automatic logic [DIFF_W-1:0] abs_diff(input logic [IDX_W-1:0] a,
                                                   input logic [FIELD_W-1:0] b);
        logic [DIFF_W-1:0] da;
        logic [DIFF_W-1:0] db;
        begin
            da = DIFF_W'(a);
            db = DIFF_W'(b);
            abs_diff = (da >= db) ? (da - db) : (db - da);
        end
    endfunction

    // Clamp an input index to the grid.
    function automatic logic [IDX_W-1:0] clamp_idx(input logic [FIELD_W-1:0] v);
        begin
            clamp_idx = (v > DIM_MAX) ? IDX_W'(MAX_DIM) : IDX_W'(v);
        end
    endfunction

endpackage

// ===== hw/rtl/gpck_cell.sv =====
// One storage cell of the column chain: holds one column count.
// Depends on gpck_pkg.
module gpck_cell (
    input  logic             clk,
    input  logic             en,
    input  gpck_pkg::count_t d,
    output gpck_pkg::count_t q
);

    gpck_pkg::count_t count_reg;
    gpck_pkg::count_t count_next;

    // Advance on enable, hold otherwise.
    assign count_next = en ? d : count_reg;

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
    end

    assign q = count_reg;

endmodule

// ===== hw/rtl/gpck_update.sv =====
// Cell update rule: knight blocking, origin, edge copy and interior add.
// Depends on gpck_pkg.
module gpck_update (
    input  gpck_pkg::pos_t   pos,
    input  gpck_pkg::count_t up,
    input  gpck_pkg::count_t left,
    output gpck_pkg::count_t count
);

    logic [gpck_pkg::DIFF_W-1:0] dr;
    logic [gpck_pkg::DIFF_W-1:0] dc;
    logic                        blocked;
    logic                        row0;
    logic                        col0;

    assign dr = gpck_pkg::abs_diff(pos.row, pos.knight_row);
    assign dc = gpck_pkg::abs_diff(pos.col, pos.knight_col);

    assign blocked = ((dr == gpck_pkg::DIFF_W'(0)) && (dc == gpck_pkg::DIFF_W'(0)))
                  || ((dr == gpck_pkg::DIFF_W'(1)) && (dc == gpck_pkg::DIFF_W'(2)))
                  || ((dr == gpck_pkg::DIFF_W'(2)) && (dc == gpck_pkg::DIFF_W'(1)));

    assign row0 = (pos.row == '0);
    assign col0 = (pos.col == '0);

    always_comb
    begin
        priority if (blocked)
            count = '0;
        else if (row0 && col0)
            count = gpck_pkg::CNT_W'(1);
        else if (row0)
            count = left;
        else if (col0)
            count = up;
        else
            count = up + left;
    end

endmodule

// ===== hw/rtl/grid_path_count_knight_blocked_top.sv =====
// Top level of the knight-blocked lattice path counter.
// Depends on gpck_pkg, gpck_cell, gpck_update and assert_macros.svh.
//
// Channel   Direction  Signals                      Payload
// s_axis    in         s_tvalid s_tready s_tdata    target_row/col, knight_row/col
// m_axis    out        m_tvalid m_tready m_tdata    path_count
//
// An item sweeps target_row * (MAX_DIM + 1) + target_col + 1 grid cells
// (at most 1089), one grid cell per cycle unless the last cell stalls,
// through the single update unit at the head of a ring of MAX_DIM + 1
// column cells. The ring rotates one position per step, so the cell at
// its tail always holds the count of the same column from the row above.
// Reset clears only control state; the column cells carry no reset because
// every count read is written earlier in the same item.
// A result waits in the output register; the sweep stalls on its last cell
// only while a previous result is still untaken.
module grid_path_count_knight_blocked_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [5:0] target_row, [11:6] target_col, [17:12] knight_row, [23:18] knight_col
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [60:0] path_count, [63:61] zero
    output logic [63:0] m_tdata
);

    `include "assert_macros.svh"

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;
    localparam int   FW      = gpck_pkg::FIELD_W;
    localparam int   IW      = gpck_pkg::IDX_W;
    localparam int   NC      = gpck_pkg::NUM_COLS;

    logic                state_reg, state_next;
    logic [IW-1:0]       row_reg, row_next;
    logic [IW-1:0]       col_reg, col_next;
    logic [IW-1:0]       rows_reg, rows_next;
    logic [IW-1:0]       cols_reg, cols_next;
    logic [FW-1:0]       krow_reg, krow_next;
    logic [FW-1:0]       kcol_reg, kcol_next;
    logic                out_valid_reg, out_valid_next;
    gpck_pkg::count_t    out_reg, out_next;

    logic                in_req;
    logic                last_cell;
    logic                step;
    gpck_pkg::pos_t      pos;
    gpck_pkg::count_t    new_count;
    gpck_pkg::count_t    cell_d [NC];
    gpck_pkg::count_t    cell_q [NC];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_req    = s_tvalid && s_tready;
    assign last_cell = (row_reg == rows_reg) && (col_reg == cols_reg);
    // Hold the final cell while the output slot is still occupied.
    assign step      = (state_reg == ST_RUN) && !(last_cell && out_valid_reg && !m_tready);

    assign pos.row        = row_reg;
    assign pos.col        = col_reg;
    assign pos.knight_row = krow_reg;
    assign pos.knight_col = kcol_reg;

    // Head update: left is the column just computed, up is the ring's tail.
    gpck_update u_update (
        .pos   (pos),
        .up    (cell_q[NC-1]),
        .left  (cell_q[0]),
        .count (new_count)
    );

    // Ring of column cells; each hands its count to the next every step.
    genvar k;
    generate
        for (k = 0; k < NC; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                assign cell_d[k] = new_count;
            end
            else
            begin : g_body
                assign cell_d[k] = cell_q[k-1];
            end
            gpck_cell u_cell (
                .clk (clk),
                .en  (step),
                .d   (cell_d[k]),
                .q   (cell_q[k])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        krow_next      = krow_reg;
        kcol_next      = kcol_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        // Drop the result once it is taken.
        if (m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_req)
                begin
                    rows_next  = gpck_pkg::clamp_idx(s_tdata[FW-1:0]);
                    cols_next  = gpck_pkg::clamp_idx(s_tdata[2*FW-1:FW]);
                    krow_next  = s_tdata[3*FW-1:2*FW];
                    kcol_next  = s_tdata[4*FW-1:3*FW];
                    row_next   = '0;
                    col_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (step)
                begin
                    if (last_cell)
                    begin
                        out_next       = new_count;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else if (col_reg == IW'(gpck_pkg::MAX_DIM))
                    begin
                        // Advance to the next row; the ring has rotated fully.
                        col_next = '0;
                        row_next = row_reg + IW'(1);
                    end
                    else
                    begin
                        col_next = col_reg + IW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rows_reg <= rows_next;
        cols_reg <= cols_next;
        krow_reg <= krow_next;
        kcol_reg <= kcol_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(64 - gpck_pkg::CNT_W){1'b0}}, out_reg};

    `ASSERT_NEXT(a_start_origin, in_req,
        (state_reg == ST_RUN) && (row_reg == '0) && (col_reg == '0),
        "sweep did not start at the origin")
    `ASSERT_SAME(a_col_range, state_reg == ST_RUN,
        col_reg <= IW'(gpck_pkg::MAX_DIM),
        "column index beyond the grid")
    `ASSERT_SAME(a_row_range, state_reg == ST_RUN,
        row_reg <= rows_reg,
        "row index beyond the target row")
    `ASSERT_SAME(a_result_source, $rose(m_tvalid),
        $past(state_reg) == ST_RUN,
        "result appeared without a sweep")

endmodule

// ===== tb/sv/grid_path_count_knight_blocked_checker.sv =====
// Checker for the knight-blocked lattice path counter: watches both stream channels,
// predicts every path count and compares it with the one the block returns.
// Depends on gpck_pkg for the count type and the grid size.
module grid_path_count_knight_blocked_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    output int          failures,
    output int          pending,
    output int          results_seen,
    output int          zero_results
);
    timeunit 1ns;
    timeprecision 1ps;

    gpck_pkg::count_t pending_counts[$];

    initial
    begin
        failures = 0;
        pending = 0;
        results_seen = 0;
        zero_results = 0;
    end

    // True when (r, c) is the knight square or one knight move away from it.
    function automatic bit knight_covers(input int r, input int c, input int kr, input int kc);
        int dr;
        int dc;
        dr = (r > kr) ? r - kr : kr - r;
        dc = (c > kc) ? c - kc : kc - c;
        return (dr == 0 && dc == 0) || (dr == 1 && dc == 2) || (dr == 2 && dc == 1);
    endfunction

    // Sweep the grid row by row through one row of counts, as the block does.
    function automatic gpck_pkg::count_t knight_path_count(input logic [23:0] request);
        longint unsigned line_counts [0:gpck_pkg::MAX_DIM];
        int rows;
        int cols;
        int kr;
        int kc;
        rows = (request[5:0] > gpck_pkg::MAX_DIM) ? gpck_pkg::MAX_DIM : int'(request[5:0]);
        cols = (request[11:6] > gpck_pkg::MAX_DIM) ? gpck_pkg::MAX_DIM : int'(request[11:6]);
        kr = int'(request[17:12]);
        kc = int'(request[23:18]);
        for (int r = 0; r <= rows; r++)
        begin
            for (int c = 0; c <= cols; c++)
            begin
                if (knight_covers(r, c, kr, kc))
                    line_counts[c] = 0;
                else if (r == 0 && c == 0)
                    line_counts[c] = 1;
                else if (r == 0)
                    line_counts[c] = line_counts[c - 1];
                else if (c != 0)
                    line_counts[c] = line_counts[c] + line_counts[c - 1];
            end
        end
        return gpck_pkg::count_t'(line_counts[cols]);
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        failures++;
    endtask

    always @(posedge clk)
    begin
        gpck_pkg::count_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                pending_counts.push_back(knight_path_count(s_tdata));
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (m_tdata[60:0] == '0)
                    zero_results++;
                if (pending_counts.size() == 0)
                    flag_mismatch($sformatf("result %0d with no request waiting",
                                            m_tdata[60:0]));
                else
                begin
                    want = pending_counts.pop_front();
                    if (m_tdata[60:0] !== want)
                        flag_mismatch($sformatf("path_count got %0d, want %0d",
                                                m_tdata[60:0], want));
                    if (m_tdata[63:61] !== 3'b000)
                        flag_mismatch($sformatf("pad bits of result are %b",
                                                m_tdata[63:61]));
                end
            end
            pending = pending_counts.size();
        end
    end

endmodule

// ===== tb/sv/grid_path_count_knight_blocked_top_tb.sv =====
// Testbench top for the knight-blocked lattice path counter: clock, reset, request
// stimulus with random gaps and result back-pressure, and the final verdict.
// Depends on gpck_pkg, the RTL top and grid_path_count_knight_blocked_checker.
module grid_path_count_knight_blocked_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 530;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // [5:0] target_row, [11:6] target_col, [17:12] knight_row, [23:18] knight_col
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // [60:0] path_count, [63:61] zero
    logic [63:0] m_tdata;

    int failures;
    int pending;
    int results_seen;
    int zero_results;
    int requests_sent;
    int clamped_targets;

    grid_path_count_knight_blocked_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    grid_path_count_knight_blocked_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .failures     (failures),
        .pending      (pending),
        .results_seen (results_seen),
        .zero_results (zero_results)
    );

    // 12 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Idle length: half the time none, mostly short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    // Present one request from the falling edge, hold it until the block takes it,
    // then idle for a random gap with junk on the data bus.
    task automatic send_request(input logic [5:0] tr, input logic [5:0] tc,
                                input logic [5:0] kr, input logic [5:0] kc);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {kc, kr, tc, tr};
        do
            @(posedge clk);
        while (!s_tready);
        requests_sent++;
        if (tr > 6'd32 || tc > 6'd32)
            clamped_targets++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata  <= 24'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Result side: ready bursts, some of them long enough to cover several whole
    // sweeps, broken by stalls drawn like the sender gaps.
    initial
    begin
        int burst;
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            burst = ($urandom_range(0, 99) < 15) ? $urandom_range(500, 3000)
                                                 : $urandom_range(1, 20);
            stall = pick_gap();
            @(negedge clk);
            m_tready <= 1'b1;
            repeat (burst - 1) @(negedge clk);
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    // Main stimulus.
    initial
    begin
        logic [5:0] tr;
        logic [5:0] tc;
        logic [5:0] kr;
        logic [5:0] kc;
        int roll;
        requests_sent = 0;
        clamped_targets = 0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed corners: origin alone, origin blocked, largest grid, clamped
        // targets, blocked target, knight moves cutting the first row or column,
        // knight squares beyond the swept grid, all-zero and all-one fields.
        send_request(6'd0,  6'd0,  6'd10, 6'd10);
        send_request(6'd0,  6'd0,  6'd0,  6'd0);
        send_request(6'd1,  6'd2,  6'd0,  6'd0);
        send_request(6'd32, 6'd32, 6'd63, 6'd63);
        send_request(6'd63, 6'd63, 6'd63, 6'd63);
        send_request(6'd40, 6'd5,  6'd50, 6'd50);
        send_request(6'd5,  6'd40, 6'd50, 6'd50);
        send_request(6'd33, 6'd33, 6'd16, 6'd16);
        send_request(6'd32, 6'd32, 6'd16, 6'd16);
        send_request(6'd5,  6'd5,  6'd5,  6'd5);
        send_request(6'd5,  6'd5,  6'd3,  6'd4);
        send_request(6'd0,  6'd10, 6'd1,  6'd4);
        send_request(6'd10, 6'd0,  6'd4,  6'd1);
        send_request(6'd3,  6'd3,  6'd33, 6'd33);
        send_request(6'd32, 6'd32, 6'd34, 6'd31);
        send_request(6'd32, 6'd32, 6'd33, 6'd34);
        send_request(6'd0,  6'd32, 6'd2,  6'd31);
        send_request(6'd32, 6'd0,  6'd0,  6'd63);
        send_request(6'd0,  6'd1,  6'd2,  6'd2);
        send_request(6'd1,  6'd0,  6'd2,  6'd2);
        send_request(6'd1,  6'd1,  6'd1,  6'd1);

        // Random part: mostly small grids to keep sweeps short, some over the
        // full field range (clamping included), a few near the largest grid.
        // Keep the knight near the grid most of the time so it cuts paths.
        repeat (RANDOM_REQUESTS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
            begin
                tr = 6'($urandom_range(0, 8));
                tc = 6'($urandom_range(0, 8));
            end
            else if (roll < 90)
            begin
                tr = 6'($urandom_range(0, 63));
                tc = 6'($urandom_range(0, 63));
            end
            else
            begin
                tr = 6'($urandom_range(25, 32));
                tc = 6'($urandom_range(25, 32));
            end
            if ($urandom_range(0, 99) < 70)
            begin
                kr = 6'($urandom_range(0, ((tr > 6'd32) ? 32 : int'(tr)) + 2));
                kc = 6'($urandom_range(0, ((tc > 6'd32) ? 32 : int'(tc)) + 2));
            end
            else
            begin
                kr = 6'($urandom_range(0, 63));
                kc = 6'($urandom_range(0, 63));
            end
            send_request(tr, tc, kr, kc);
        end

        // Drop valid, drain every expected result, then let the block settle.
        @(negedge clk);
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (40) @(negedge clk);

        $display("Sent %0d requests (%0d with clamped targets); checked %0d path counts,",
                 requests_sent, clamped_targets, results_seen);
        $display("%0d of them zero from a blocked origin, target or cut-off grid.",
                 zero_results);
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard limit, several times the slowest correct run.
    initial
    begin
        #40_000_000;
        $display("Timeout with %0d results still expected", pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
